// ===== hw/rtl/ipc_pkg.sv =====
// Shared types, constants and register indexes for the irrigation pump controller.
package ipc_pkg;

  // Field widths.
  localparam int MOIST_W = 15;
  localparam int TIME_W  = 32;
  localparam int MODE_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Moving average depth and full scale (100 percent with 8 fraction bits).
  localparam int SAMPLES = 20;
  localparam int FULL_SCALE_I = 25600;
  localparam logic [MOIST_W-1:0] FULL_SCALE = MOIST_W'(FULL_SCALE_I);

  // Running sum and ring pointer widths.
  localparam int SUM_W = $clog2(SAMPLES * FULL_SCALE_I + 1);
  localparam int POS_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(SAMPLES - 1);

  // Reciprocal for sum / SAMPLES: ceil(2^k / SAMPLES) with k large enough that
  // the truncated product is exact for every sum below 2^SUM_W.
  localparam int RECIP_SH = SUM_W + $clog2(SAMPLES);
  localparam int RECIP_I  = ((2 ** RECIP_SH) + SAMPLES - 1) / SAMPLES;
  localparam int RECIP_W  = $clog2(RECIP_I + 1);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_I);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DRY_LEVEL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_LEVEL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_FLOOR  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PUMP_LIMIT_MS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SOAK_MS       = 3'd4;

  // Configuration reset values.
  localparam logic [MOIST_W-1:0] DRY_LEVEL_RST     = 15'd7680;
  localparam logic [MOIST_W-1:0] WET_LEVEL_RST     = 15'd15360;
  localparam logic [MOIST_W-1:0] SENSOR_FLOOR_RST  = 15'd128;
  localparam logic [TIME_W-1:0]  PUMP_LIMIT_MS_RST = 32'd20000;
  localparam logic [TIME_W-1:0]  SOAK_MS_RST       = 32'd15000;

  // Controller modes.
  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE        = 3'd0,
    MODE_AUTO        = 3'd1,
    MODE_MANUAL      = 3'd2,
    MODE_SOAK        = 3'd3,
    MODE_ERR_TIMEOUT = 3'd4,
    MODE_ERR_SENSOR  = 3'd5
  } mode_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [MOIST_W-1:0] dry_level;
    logic [MOIST_W-1:0] wet_level;
    logic [MOIST_W-1:0] sensor_floor;
    logic [TIME_W-1:0]  pump_limit_ms;
    logic [TIME_W-1:0]  soak_ms;
  } cfg_t;

  // One tick after averaging, handed to the mode controller.
  typedef struct packed {
    logic [MOIST_W-1:0] average;
    logic               button;
    logic [TIME_W-1:0]  now_ms;
  } tick_t;

  // One result item.
  typedef struct packed {
    logic               pump_on;
    mode_t              mode;
    logic [MOIST_W-1:0] average;
  } res_t;

endpackage

// ===== hw/rtl/irrigation_pump_controller_core.sv =====
// Top level of the irrigation pump controller: config registers, result register, assertions.
//
//   Channel   Direction  Handshake              Payload
//   in_       input      in_valid / in_ready    moisture_sample, button_pressed, now_ms
//   out_      output     out_valid / out_ready  pump_on, mode, average
//   cfg_      input      cfg_valid / cfg_ready  cfg_index (3 bits), cfg_data (32 bits)
//
// One item per cycle is sustained while out_ready stays high; after the input transfer the item
// passes the averaging stages s1, s2 and s3 and then the result register before out_valid rises.
// The throughput is set by the ring and running-sum update, and by the mode register,
// which both feed their own next value back without a pipeline break.
// Reset clears all valid bits, the ring state, the mode and timestamps, and loads the
// configuration defaults; there is no clearing pass, the first sample fills the ring.
// Each stage holds its item while the next one is full and stalled; cfg_ready is always high.
module irrigation_pump_controller_core import ipc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [MOIST_W-1:0]    in_moisture_sample,
  input  logic                  in_button_pressed,
  input  logic [TIME_W-1:0]     in_now_ms,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_pump_on,
  output logic [MODE_W-1:0]     out_mode,
  output logic [MOIST_W-1:0]    out_average,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg_r;
  logic  avg_valid;
  logic  avg_ready;
  tick_t avg_tick;
  logic  advance;
  res_t  res;
  logic  out_valid_r;
  res_t  out_res_r;

  // Moving average pipeline.
  ipc_avg u_avg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_moisture_sample),
    .in_button (in_button_pressed),
    .in_now_ms (in_now_ms),
    .out_valid (avg_valid),
    .out_ready (avg_ready),
    .out_tick  (avg_tick)
  );

  // The result register takes a tick when it is empty or its result is taken.
  assign avg_ready = !out_valid_r || out_ready;
  assign advance   = avg_valid && avg_ready;

  // Mode controller.
  ipc_mode u_mode (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .tick    (avg_tick),
    .cfg     (cfg_r),
    .res     (res)
  );

  // Configuration writes; an unknown index is ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dry_level     <= DRY_LEVEL_RST;
      cfg_r.wet_level     <= WET_LEVEL_RST;
      cfg_r.sensor_floor  <= SENSOR_FLOOR_RST;
      cfg_r.pump_limit_ms <= PUMP_LIMIT_MS_RST;
      cfg_r.soak_ms       <= SOAK_MS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DRY_LEVEL:     cfg_r.dry_level     <= cfg_data[MOIST_W-1:0];
        CFG_WET_LEVEL:     cfg_r.wet_level     <= cfg_data[MOIST_W-1:0];
        CFG_SENSOR_FLOOR:  cfg_r.sensor_floor  <= cfg_data[MOIST_W-1:0];
        CFG_PUMP_LIMIT_MS: cfg_r.pump_limit_ms <= cfg_data[TIME_W-1:0];
        CFG_SOAK_MS:       cfg_r.soak_ms       <= cfg_data[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (avg_ready) begin
      out_valid_r <= avg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pump_on = out_res_r.pump_on;
  assign out_mode    = out_res_r.mode;
  assign out_average = out_res_r.average;

  // The average of saturated samples never exceeds full scale.
  a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_average <= FULL_SCALE))
    else $error("average above full scale");

  // A failed health check never drives the pump.
  a_floor_no_pump: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_average < cfg_r.sensor_floor)) |-> !out_pump_on)
    else $error("pump driven with average below sensor floor");

  // A pumping tick ends in a watering mode, idle or a timeout error.
  a_pump_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pump_on) |->
      ((out_mode == MODE_AUTO) || (out_mode == MODE_MANUAL) ||
       (out_mode == MODE_IDLE) || (out_mode == MODE_ERR_TIMEOUT)))
    else $error("pump on with an unexpected next mode");

endmodule

// ===== hw/rtl/ipc_avg.sv =====
// Moving average unit: sample ring, running sum and reciprocal divide, three stages.
module ipc_avg import ipc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [MOIST_W-1:0] in_sample,
  input  logic               in_button,
  input  logic [TIME_W-1:0]  in_now_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output tick_t              out_tick
);

  // Stage one holds the saturated sample.
  logic               s1_valid_r;
  logic [MOIST_W-1:0] s1_sample_r;
  logic               s1_button_r;
  logic [TIME_W-1:0]  s1_now_r;

  // Stage two holds the tick whose sum sits in sum_r.
  logic               s2_valid_r;
  logic               s2_button_r;
  logic [TIME_W-1:0]  s2_now_r;

  // Stage three holds the finished average.
  logic  s3_valid_r;
  tick_t s3_tick_r;

  // Ring state.
  logic [MOIST_W-1:0] ring_r [SAMPLES];
  logic [POS_W-1:0]   pos_r;
  logic [POS_W-1:0]   pos_nxt;
  logic [POS_W-1:0]   pos_base;
  logic [SUM_W-1:0]   sum_r;
  logic [SUM_W-1:0]   sum_nxt;
  logic               primed_r;

  logic [MOIST_W-1:0] in_sat;
  logic               s3_ready;
  logic               s2_ready;
  logic               s1_move;
  logic               s2_move;
  logic [SUM_W+RECIP_W-1:0] prod;

  // Each stage takes a new item when it is empty or its content moves on.
  assign s3_ready = !s3_valid_r || out_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign in_ready = !s1_valid_r || s2_ready;
  assign s1_move  = s1_valid_r && s2_ready;
  assign s2_move  = s2_valid_r && s3_ready;

  // Samples above full scale are clipped.
  assign in_sat = (in_sample > FULL_SCALE) ? FULL_SCALE : in_sample;

  // The first sample fills the whole ring, so its sum is SAMPLES times the sample
  // and the ring pointer restarts at slot zero.
  always_comb begin
    if (!primed_r) begin
      sum_nxt  = SUM_W'(SUM_W'(s1_sample_r) * SUM_W'(SAMPLES));
      pos_base = '0;
    end else begin
      sum_nxt  = sum_r - SUM_W'(ring_r[pos_r]) + SUM_W'(s1_sample_r);
      pos_base = pos_r;
    end
    pos_nxt = (pos_base == POS_LAST) ? '0 : pos_base + POS_W'(1);
  end

  // Average is the sum times the reciprocal, truncated.
  assign prod = SUM_W'(sum_r) * RECIP;

  // Control registers of the pipeline and the ring.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      pos_r      <= '0;
      sum_r      <= '0;
      primed_r   <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_ready) begin
        s3_valid_r <= s2_valid_r;
      end
      if (s1_move) begin
        pos_r    <= pos_nxt;
        sum_r    <= sum_nxt;
        primed_r <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample_r <= in_sat;
      s1_button_r <= in_button;
      s1_now_r    <= in_now_ms;
    end
    if (s1_move) begin
      s2_button_r <= s1_button_r;
      s2_now_r    <= s1_now_r;
      for (int i = 0; i < SAMPLES; i++) begin
        if (!primed_r || (pos_r == POS_W'(i))) begin
          ring_r[i] <= s1_sample_r;
        end
      end
    end
    if (s2_move) begin
      s3_tick_r.average <= MOIST_W'(prod >> RECIP_SH);
      s3_tick_r.button  <= s2_button_r;
      s3_tick_r.now_ms  <= s2_now_r;
    end
  end

  assign out_valid = s3_valid_r;
  assign out_tick  = s3_tick_r;

endmodule

// ===== hw/rtl/ipc_mode.sv =====
// Pump mode controller: health check, mode transition and pump timestamps.
module ipc_mode import ipc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  advance,
  input  tick_t tick,
  input  cfg_t  cfg,
  output res_t  res
);

  mode_t             mode_r;
  mode_t             mode_nxt;
  mode_t             mode_chk;
  logic [TIME_W-1:0] start_r;
  logic [TIME_W-1:0] start_nxt;
  logic [TIME_W-1:0] end_r;
  logic [TIME_W-1:0] end_nxt;
  logic              run_over;
  logic              soak_over;
  logic              pump;

  // Elapsed times wrap with the millisecond counter.
  assign run_over  = (tick.now_ms - start_r) > cfg.pump_limit_ms;
  assign soak_over = (tick.now_ms - end_r) > cfg.soak_ms;

  // A low average flags a missing sensor unless a timeout error is pending.
  assign mode_chk = ((tick.average < cfg.sensor_floor) && (mode_r != MODE_ERR_TIMEOUT)) ?
                    MODE_ERR_SENSOR : mode_r;
  assign pump = (mode_chk == MODE_AUTO) || (mode_chk == MODE_MANUAL);

  // Next mode and timestamps.
  always_comb begin
    mode_nxt  = mode_chk;
    start_nxt = start_r;
    end_nxt   = end_r;
    case (mode_chk)
      MODE_AUTO: begin
        if (tick.average > cfg.wet_level) begin
          mode_nxt = MODE_IDLE;
          end_nxt  = tick.now_ms;
        end else if (run_over) begin
          mode_nxt = MODE_ERR_TIMEOUT;
          end_nxt  = tick.now_ms;
        end
      end
      MODE_MANUAL: begin
        // The timeout test wins over a released button.
        if (run_over) begin
          mode_nxt = MODE_ERR_TIMEOUT;
          end_nxt  = tick.now_ms;
        end else if (!tick.button) begin
          mode_nxt = MODE_IDLE;
          end_nxt  = tick.now_ms;
        end
      end
      MODE_SOAK: begin
        if (tick.button) begin
          mode_nxt  = MODE_MANUAL;
          start_nxt = tick.now_ms;
        end else if (soak_over) begin
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_ERR_TIMEOUT, MODE_ERR_SENSOR: begin
        if (tick.button) begin
          mode_nxt = MODE_IDLE;
          end_nxt  = tick.now_ms;
        end
      end
      default: begin
        // Idle, and any unused code, behaves as idle.
        if (tick.button) begin
          mode_nxt  = MODE_MANUAL;
          start_nxt = tick.now_ms;
        end else if (tick.average < cfg.dry_level) begin
          if (soak_over) begin
            mode_nxt  = MODE_AUTO;
            start_nxt = tick.now_ms;
          end else begin
            mode_nxt = MODE_SOAK;
          end
        end else begin
          mode_nxt = MODE_IDLE;
        end
      end
    endcase
  end

  // Controller state advances once per transfer into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      start_r <= '0;
      end_r   <= '0;
    end else if (advance) begin
      mode_r  <= mode_nxt;
      start_r <= start_nxt;
      end_r   <= end_nxt;
    end
  end

  assign res.pump_on = pump;
  assign res.mode    = mode_nxt;
  assign res.average = tick.average;

endmodule

// ===== tb/ipc_pump_checker.sv =====
// Checker for the irrigation pump controller: tracks the block's state and compares every result.
`timescale 1ns / 1ps

module ipc_pump_checker import ipc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [MOIST_W-1:0]    in_moisture_sample,
  input  logic                  in_button_pressed,
  input  logic [TIME_W-1:0]     in_now_ms,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_pump_on,
  input  logic [MODE_W-1:0]     out_mode,
  input  logic [MOIST_W-1:0]    out_average,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    reports_due
);

  // Local copy of the configuration registers.
  cfg_t settings;

  // Local copy of the controller and moving-average state.
  mode_t              mode_now;
  logic [TIME_W-1:0]  pump_started;
  logic [TIME_W-1:0]  pump_stopped;
  logic [MOIST_W-1:0] moist_ring [SAMPLES];
  logic [POS_W-1:0]   ring_slot;
  logic [SUM_W-1:0]   moist_sum;
  logic               ring_filled;

  // Results of accepted ticks that have not come out yet, oldest first.
  res_t pump_reports[$];

  // Advances the state by one loop tick and returns the result it produces.
  function automatic res_t run_pump_tick(input logic [MOIST_W-1:0] raw, input logic btn,
                                         input logic [TIME_W-1:0] now);
    logic [MOIST_W-1:0] smp;
    logic [MOIST_W-1:0] avg;
    logic [TIME_W-1:0]  since_start;
    logic [TIME_W-1:0]  since_stop;
    mode_t              cur;
    res_t               r;
    int                 i;
    smp = (raw > FULL_SCALE) ? FULL_SCALE : raw;

    // The first sample after reset fills the whole ring.
    if (!ring_filled) begin
      for (i = 0; i < SAMPLES; i++) moist_ring[i] = smp;
      moist_sum   = SUM_W'(smp * SAMPLES);
      ring_slot   = '0;
      ring_filled = 1'b1;
    end
    moist_sum = moist_sum - SUM_W'(moist_ring[ring_slot]) + SUM_W'(smp);
    moist_ring[ring_slot] = smp;
    ring_slot = (ring_slot == POS_LAST) ? '0 : ring_slot + 1'b1;
    avg = MOIST_W'(moist_sum / SAMPLES);

    // Health check, then the pump follows the mode the tick runs in.
    cur = mode_now;
    if (avg < settings.sensor_floor && cur != MODE_ERR_TIMEOUT) cur = MODE_ERR_SENSOR;
    r.pump_on = (cur == MODE_AUTO || cur == MODE_MANUAL);
    since_start = now - pump_started;
    since_stop  = now - pump_stopped;

    // Mode transition.
    case (cur)
      MODE_AUTO: begin
        if (avg > settings.wet_level) begin
          cur = MODE_IDLE;
          pump_stopped = now;
        end else if (since_start > settings.pump_limit_ms) begin
          cur = MODE_ERR_TIMEOUT;
          pump_stopped = now;
        end
      end
      MODE_MANUAL: begin
        if (!btn) begin
          cur = MODE_IDLE;
          pump_stopped = now;
        end
        // A timeout overrides a release in the same tick.
        if (since_start > settings.pump_limit_ms) begin
          cur = MODE_ERR_TIMEOUT;
          pump_stopped = now;
        end
      end
      MODE_SOAK: begin
        if (since_stop > settings.soak_ms) cur = MODE_IDLE;
        if (btn) begin
          cur = MODE_MANUAL;
          pump_started = now;
        end
      end
      MODE_ERR_TIMEOUT, MODE_ERR_SENSOR: begin
        if (btn) begin
          cur = MODE_IDLE;
          pump_stopped = now;
        end
      end
      default: begin
        if (btn) begin
          cur = MODE_MANUAL;
          pump_started = now;
        end else if (avg < settings.dry_level) begin
          if (since_stop > settings.soak_ms) begin
            cur = MODE_AUTO;
            pump_started = now;
          end else begin
            cur = MODE_SOAK;
          end
        end else begin
          cur = MODE_IDLE;
        end
      end
    endcase
    mode_now  = cur;
    r.mode    = cur;
    r.average = avg;
    return r;
  endfunction

  // Reports one field that differs from its prediction.
  task automatic check_field(input string fname, input logic [MOIST_W-1:0] want,
                             input logic [MOIST_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // All channels are sampled at the rising edge.
  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      settings.dry_level     = DRY_LEVEL_RST;
      settings.wet_level     = WET_LEVEL_RST;
      settings.sensor_floor  = SENSOR_FLOOR_RST;
      settings.pump_limit_ms = PUMP_LIMIT_MS_RST;
      settings.soak_ms       = SOAK_MS_RST;
      mode_now     = MODE_IDLE;
      pump_started = '0;
      pump_stopped = '0;
      ring_slot    = '0;
      moist_sum    = '0;
      ring_filled  = 1'b0;
      pump_reports.delete();
      mismatches   = 0;
    end else begin
      // Register write transfer; unknown indexes are ignored.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DRY_LEVEL:     settings.dry_level     = cfg_data[MOIST_W-1:0];
          CFG_WET_LEVEL:     settings.wet_level     = cfg_data[MOIST_W-1:0];
          CFG_SENSOR_FLOOR:  settings.sensor_floor  = cfg_data[MOIST_W-1:0];
          CFG_PUMP_LIMIT_MS: settings.pump_limit_ms = cfg_data[TIME_W-1:0];
          CFG_SOAK_MS:       settings.soak_ms       = cfg_data[TIME_W-1:0];
          default: ;
        endcase
      end

      // Result transfer against the oldest prediction.
      if (out_valid && out_ready) begin
        if (pump_reports.size() == 0) begin
          $display("%0t: result with none due, pump_on %0d mode %0d average %0d",
                   $time, out_pump_on, out_mode, out_average);
          mismatches++;
        end else begin
          want = pump_reports.pop_front();
          check_field("pump_on", MOIST_W'(want.pump_on), MOIST_W'(out_pump_on));
          check_field("mode", MOIST_W'(want.mode), MOIST_W'(out_mode));
          check_field("average", want.average, out_average);
        end
      end

      // Tick transfer.
      if (in_valid && in_ready) begin
        pump_reports.push_back(run_pump_tick(in_moisture_sample, in_button_pressed,
                                             in_now_ms));
      end
    end
    reports_due = pump_reports.size();
  end

endmodule

// ===== tb/tb.sv =====
// Top of the irrigation pump controller testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import ipc_pkg::*;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [MOIST_W-1:0]    in_moisture_sample;
  logic                  in_button_pressed;
  logic [TIME_W-1:0]     in_now_ms;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_pump_on;
  logic [MODE_W-1:0]     out_mode;
  logic [MOIST_W-1:0]    out_average;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    mismatches;
  int                    reports_due;

  // Idle odds in percent for the sender and the receiver.
  int unsigned snd_idle = 17;
  int unsigned rcv_idle = 58;

  // Random tick shaping: moisture drift, button hold and the millisecond clock.
  int                 moist_lvl = 12000;
  int                 moist_dir = -1;
  logic               btn_held  = 1'b0;
  logic [TIME_W-1:0]  clock_ms  = '0;
  int unsigned        step_max  = 100;

  irrigation_pump_controller_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_moisture_sample (in_moisture_sample),
    .in_button_pressed  (in_button_pressed),
    .in_now_ms          (in_now_ms),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pump_on        (out_pump_on),
    .out_mode           (out_mode),
    .out_average        (out_average),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  ipc_pump_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_moisture_sample (in_moisture_sample),
    .in_button_pressed  (in_button_pressed),
    .in_now_ms          (in_now_ms),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pump_on        (out_pump_on),
    .out_mode           (out_mode),
    .out_average        (out_average),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .mismatches         (mismatches),
    .reports_due        (reports_due)
  );

  // 2 ns clock.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver stalls at random on every falling edge.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= rcv_idle);
    end
  end

  // Hard stop in case the run hangs.
  initial begin
    #400000;
    $display("irrigation_pump_controller_core test failed");
    $finish;
  end

  // Offers one tick after a random gap and holds it until the transfer.
  task automatic send_tick(input logic [MOIST_W-1:0] smp, input logic btn,
                           input logic [TIME_W-1:0] now);
    while ($urandom_range(99) < snd_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid           = 1'b1;
    in_moisture_sample = smp;
    in_button_pressed  = btn;
    in_now_ms          = now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Holds off new ticks until every result has come out.
  task automatic settle_block();
    in_valid = 1'b0;
    while (reports_due != 0) @(negedge clk);
  endtask

  // One register write transfer.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Loads one of the register settings while the block is idle.
  task automatic apply_setting(input int sel);
    logic [CFG_DATA_W-1:0] dry;
    logic [CFG_DATA_W-1:0] wet;
    logic [CFG_DATA_W-1:0] flr;
    logic [CFG_DATA_W-1:0] lim;
    logic [CFG_DATA_W-1:0] soak;
    logic [CFG_DATA_W-1:0] span;
    case (sel)
      0: begin
        dry  = CFG_DATA_W'(DRY_LEVEL_RST);
        wet  = CFG_DATA_W'(WET_LEVEL_RST);
        flr  = CFG_DATA_W'(SENSOR_FLOOR_RST);
        lim  = CFG_DATA_W'(PUMP_LIMIT_MS_RST);
        soak = CFG_DATA_W'(SOAK_MS_RST);
      end
      1: begin
        // Short timers so that timeouts and soaking come often.
        dry  = $urandom_range(12000, 2000);
        wet  = $urandom_range(25600, dry);
        flr  = $urandom_range(1500);
        lim  = $urandom_range(400, 50);
        soak = $urandom_range(300, 20);
      end
      2: begin
        dry  = CFG_DATA_W'(FULL_SCALE);
        wet  = '0;
        flr  = '0;
        lim  = '0;
        soak = '0;
      end
      3: begin
        dry  = '0;
        wet  = CFG_DATA_W'({MOIST_W{1'b1}});
        flr  = '0;
        lim  = '1;
        soak = '1;
      end
      default: begin
        // Raw words: the upper bits of the narrow registers are dropped.
        dry  = $urandom;
        wet  = $urandom;
        flr  = $urandom;
        lim  = $urandom;
        soak = $urandom;
      end
    endcase
    settle_block();
    write_reg(CFG_DRY_LEVEL, dry);
    write_reg(CFG_WET_LEVEL, wet);
    write_reg(CFG_SENSOR_FLOOR, flr);
    write_reg(CFG_PUMP_LIMIT_MS, lim);
    write_reg(CFG_SOAK_MS, soak);

    // Time steps scale with the longer of the two timers.
    span = (lim > soak) ? lim : soak;
    step_max = (span >= 32'h4000_0000) ? 32'h4000_0000 : span / 4 + 2;
  endtask

  // One random tick: mostly a drifting moisture level with a held button, some noise.
  task automatic random_tick();
    int                smp;
    int unsigned       pick;
    logic [TIME_W-1:0] dt;
    pick = $urandom_range(99);
    if (pick < 12) begin
      send_tick(MOIST_W'($urandom_range(32767)), 1'($urandom_range(1)), $urandom);
    end else begin
      if ($urandom_range(9) == 0) moist_dir = -moist_dir;
      moist_lvl = moist_lvl + moist_dir * int'($urandom_range(1800));
      if (moist_lvl < 0) moist_lvl = 0;
      if (moist_lvl > 27500) moist_lvl = 27500;
      smp = moist_lvl + int'($urandom_range(1000)) - 500;
      if (smp < 0) smp = 0;
      if (smp > 32767) smp = 32767;

      // Presses are held for a few ticks.
      if (btn_held) begin
        if ($urandom_range(3) == 0) btn_held = 1'b0;
      end else begin
        if ($urandom_range(11) == 0) btn_held = 1'b1;
      end

      pick = $urandom_range(99);
      if (pick < 70) dt = $urandom_range(step_max);
      else if (pick < 95) dt = $urandom_range(40);
      else dt = $urandom;
      clock_ms = clock_ms + dt;
      send_tick(MOIST_W'(smp), btn_held, clock_ms);
    end
  endtask

  // Stimulus and verdict.
  initial begin
    int p;
    int k;
    int n;
    int idx;
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_moisture_sample = '0;
    in_button_pressed  = 1'b0;
    in_now_ms          = '0;
    cfg_valid          = 1'b0;
    cfg_index          = CFG_DRY_LEVEL;
    cfg_data           = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // First sample fills the ring; auto watering starts just before the clock wraps.
    send_tick(15'd6000, 1'b0, 32'hFFFF_FFF0);
    send_tick(15'd6000, 1'b0, 32'hFFFF_FFFF);
    // Pump run exactly at the limit, then one past it.
    send_tick(15'd6000, 1'b0, 32'd19984);
    send_tick(15'd6000, 1'b0, 32'd19985);
    send_tick('0, 1'b0, 32'd20000);
    // Button clears the timeout, then soaking and a button press out of soaking.
    send_tick(15'd6000, 1'b1, 32'd20020);
    send_tick(15'd6000, 1'b0, 32'd20040);
    send_tick(15'd6000, 1'b1, 32'd20060);
    send_tick(15'd6000, 1'b0, 32'd20080);
    // Soaking ends only once the cooldown is strictly exceeded.
    send_tick(15'd6000, 1'b0, 32'd20100);
    send_tick(15'd6000, 1'b0, 32'd35080);
    send_tick(15'd6000, 1'b0, 32'd35081);
    send_tick(15'd6000, 1'b0, 32'd35100);
    // Samples above full scale while auto watering runs into its timeout.
    send_tick({MOIST_W{1'b1}}, 1'b1, 32'd35120);
    send_tick(FULL_SCALE, 1'b0, 32'd55101);
    send_tick(FULL_SCALE + 15'd1, 1'b1, 32'd55120);
    // Manual watering where release and timeout land on the same tick.
    send_tick(FULL_SCALE, 1'b1, 32'd55140);
    send_tick(FULL_SCALE, 1'b1, 32'd75140);
    send_tick(FULL_SCALE, 1'b0, 32'd75141);
    send_tick(FULL_SCALE, 1'b1, 32'd75160);

    // Dry threshold above full scale with no cooldown: auto, then wet exit at once.
    settle_block();
    write_reg(CFG_DRY_LEVEL, CFG_DATA_W'({MOIST_W{1'b1}}));
    write_reg(CFG_WET_LEVEL, '0);
    write_reg(CFG_SOAK_MS, '0);
    send_tick(FULL_SCALE, 1'b0, 32'd75180);
    send_tick(FULL_SCALE, 1'b0, 32'd75200);

    // Sensor floor above full scale: sensor error, cleared by the button, then back.
    settle_block();
    write_reg(CFG_SENSOR_FLOOR, CFG_DATA_W'({MOIST_W{1'b1}}));
    send_tick('0, 1'b0, 32'd75220);
    send_tick('0, 1'b1, 32'd75240);
    send_tick('0, 1'b0, 32'd75260);
    clock_ms = 32'd75260;

    // Writes to unused indexes must leave every register alone.
    settle_block();
    for (idx = int'(CFG_SOAK_MS) + 1; idx < (1 << CFG_IDX_W); idx++) begin
      write_reg(CFG_IDX_W'(idx), $urandom);
    end

    // Random part: three idle patterns, each across all register settings.
    for (p = 0; p < 3; p++) begin
      case (p)
        0: begin
          snd_idle = 17;
          rcv_idle = 58;
        end
        1: begin
          snd_idle = 58;
          rcv_idle = 17;
        end
        default: begin
          snd_idle = 0;
          rcv_idle = 0;
        end
      endcase
      for (k = 0; k < 5; k++) begin
        apply_setting(k);
        for (n = 0; n < 90; n++) begin
          if ($urandom_range(199) == 0) settle_block();
          random_tick();
        end
      end
    end

    // Drain, allow for the pipeline latency, then report.
    settle_block();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("irrigation_pump_controller_core test passed");
    end else begin
      $display("irrigation_pump_controller_core test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ipc_pkg.sv
hw/rtl/ipc_avg.sv
hw/rtl/ipc_mode.sv
hw/rtl/irrigation_pump_controller_core.sv
tb/ipc_pump_checker.sv
tb/tb.sv
